@@ rtl/core/iaf_pkg.sv @@
// Shared types, codes, character and BCD helpers for the integer to ASCII formatter.
`timescale 1ns / 1ps

package iaf_pkg;

	typedef enum logic [1:0] {
		CMD_DEC    = 2'd0,
		CMD_HEX_LO = 2'd1,
		CMD_HEX_UP = 2'd2,
		CMD_PTR    = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_STRIP,
		ST_PFX0,
		ST_PFXX,
		ST_EMIT
	} st_t;

	localparam int NIB_W     = 4;
	localparam int DIG_W     = 64;
	localparam int BCD_DIGS  = 10;
	localparam int BCD_W     = BCD_DIGS * NIB_W;
	localparam int BIN_W     = 32;
	localparam int NDIG_W    = 5;
	localparam int CNT_W     = 4;

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_X    = 8'h78;

	// One digit of the hex or decimal alphabet.
	function automatic logic [7:0] nib_char(input logic [3:0] nib, input cmd_t cmd);
		logic [7:0] c;
		begin
			if (nib < 4'd10) begin
				c = CH_ZERO + {4'd0, nib};
			end else if (cmd == CMD_HEX_UP) begin
				c = 8'h41 + {4'd0, nib - 4'd10};
			end else begin
				c = 8'h61 + {4'd0, nib - 4'd10};
			end
			nib_char = c;
		end
	endfunction

	// One shift-and-add-3 step: correct every BCD digit, then shift in one bit.
	function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd,
		input logic bin_bit);
		logic [BCD_W-1:0] adj;
		begin
			adj = bcd;
			for (int i = 0; i < BCD_DIGS; i++) begin
				if (bcd[i*NIB_W +: NIB_W] >= 4'd5) begin
					adj[i*NIB_W +: NIB_W] = bcd[i*NIB_W +: NIB_W] + 4'd3;
				end
			end
			dd_step = {adj[BCD_W-2:0], bin_bit};
		end
	endfunction

endpackage

@@ rtl/core/integer_to_ascii_formatter_core.sv @@
// Top level of the integer to ASCII formatter: sequencer, shared shift unit, output register.
`timescale 1ns / 1ps

// One request at a time; in_stall is high from acceptance until the last character is loaded.
// Decimal requests first run binary-to-BCD conversion (two bits per cycle through one shift
// unit); hex and pointer requests skip it. Leading zeros are then dropped one digit at a
// time, pointers load their two prefix characters, and the characters are loaded one by one
// as the output register frees up; output stalls hold the sequence.
// Reset clears the sequencer and the output valid; payload registers are not reset.
module integer_to_ascii_formatter_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  iaf_pkg::cmd_t      cmd,
	input  logic [63:0]        value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         char_out,
	output logic               last
);
	import iaf_pkg::*;

	st_t                state_q, state_d;
	cmd_t               cmd_q;
	logic [DIG_W-1:0]   dig_q;
	logic [BIN_W-1:0]   bin_q;
	logic [NDIG_W-1:0]  ndig_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               out_valid_q;
	logic [7:0]         char_q;
	logic               last_q;

	logic               accept;
	logic               out_free;
	logic               out_load;
	logic [7:0]         char_d;
	logic               last_d;
	logic               conv_step;
	logic               dig_shift;
	logic               top_zero;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign top_zero = (dig_q[DIG_W-1 -: NIB_W] == 4'd0);

	assign out_valid = out_valid_q;
	assign char_out  = char_q;
	assign last      = last_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (cmd == CMD_DEC) ? ST_CONV : ST_STRIP;
				end
			end
			ST_CONV: begin
				if (cnt_q == {CNT_W{1'b1}}) begin
					state_d = ST_STRIP;
				end
			end
			ST_STRIP: begin
				if (!(top_zero && ndig_q > NDIG_W'(1))) begin
					state_d = (cmd_q == CMD_PTR) ? ST_PFX0 : ST_EMIT;
				end
			end
			ST_PFX0: begin
				if (out_free) begin
					state_d = ST_PFXX;
				end
			end
			ST_PFXX: begin
				if (out_free) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free && ndig_q == NDIG_W'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		out_load  = 1'b0;
		char_d    = CH_ZERO;
		last_d    = 1'b0;
		conv_step = 1'b0;
		dig_shift = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
			end
			ST_CONV: begin
				conv_step = 1'b1;
			end
			ST_STRIP: begin
				dig_shift = top_zero && (ndig_q > NDIG_W'(1));
			end
			ST_PFX0: begin
				out_load = out_free;
				char_d   = CH_ZERO;
			end
			ST_PFXX: begin
				out_load = out_free;
				char_d   = CH_X;
			end
			ST_EMIT: begin
				out_load  = out_free;
				char_d    = nib_char(dig_q[DIG_W-1 -: NIB_W], cmd_q);
				last_d    = (ndig_q == NDIG_W'(1));
				dig_shift = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers: the digit word is consumed from its top nibble.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			cnt_q <= '0;
			bin_q <= value[BIN_W-1:0];
			unique case (cmd)
				CMD_DEC: begin
					dig_q  <= '0;
					ndig_q <= NDIG_W'(BCD_DIGS);
				end
				CMD_PTR: begin
					dig_q  <= value;
					ndig_q <= NDIG_W'(DIG_W / NIB_W);
				end
				default: begin
					dig_q  <= {value[BIN_W-1:0], {(DIG_W-BIN_W){1'b0}}};
					ndig_q <= NDIG_W'(BIN_W / NIB_W);
				end
			endcase
		end else if (conv_step) begin
			// Two binary bits per cycle into the BCD field at the top of the digit word.
			dig_q[DIG_W-1 -: BCD_W] <= dd_step(dd_step(dig_q[DIG_W-1 -: BCD_W], bin_q[BIN_W-1]),
				bin_q[BIN_W-2]);
			bin_q <= {bin_q[BIN_W-3:0], 2'b00};
			cnt_q <= cnt_q + CNT_W'(1);
		end else if (dig_shift) begin
			dig_q  <= {dig_q[DIG_W-NIB_W-1:0], {NIB_W{1'b0}}};
			ndig_q <= ndig_q - NDIG_W'(1);
		end
		if (out_load) begin
			char_q <= char_d;
			last_q <= last_d;
		end
	end

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the integer to ASCII formatter core.
`timescale 1ns / 1ps

module testbench;
	import iaf_pkg::*;

	localparam int NUM_DIRECTED  = 23;
	localparam int RANDOM_CHUNKS = 8;
	localparam int CHUNK_ITEMS   = 50;
	localparam int PRESSURE_AT   = NUM_DIRECTED + 12;
	localparam int HOLD_CYCLES   = 300;
	localparam int QUIET_LIMIT   = 2000;
	localparam int TAIL_CYCLES   = 40;
	localparam logic [143:0] PREDICT = '0;

	typedef enum {PH_STEADY, PH_SLOW_SRC, PH_SLOW_SINK, PH_LIGHT_BOTH} phase_t;

	// Text is right-justified: the final character sits in the low byte.
	typedef struct packed {
		cmd_t          op;
		logic [63:0]   val;
		logic [143:0]  text;
	} stim_row_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
	} char_exp_t;

	localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
		'{CMD_DEC,    64'd0,                   "0"},
		'{CMD_DEC,    64'h0000_0000_FFFF_FFFF, "4294967295"},
		'{CMD_DEC,    64'hFFFF_FFFF_0000_0001, "1"},
		'{CMD_DEC,    64'd9,                   "9"},
		'{CMD_DEC,    64'd10,                  "10"},
		'{CMD_DEC,    64'd1000000000,          "1000000000"},
		'{CMD_DEC,    64'd999999999,           "999999999"},
		'{CMD_DEC,    64'd123456789,           PREDICT},
		'{CMD_HEX_LO, 64'd0,                   "0"},
		'{CMD_HEX_LO, 64'h0000_0000_FFFF_FFFF, "ffffffff"},
		'{CMD_HEX_LO, 64'hDEAD_BEEF_0000_ABCD, "abcd"},
		'{CMD_HEX_LO, 64'h0000_0000_1000_0000, "10000000"},
		'{CMD_HEX_UP, 64'd0,                   "0"},
		'{CMD_HEX_UP, 64'h0000_0000_FFFF_FFFF, "FFFFFFFF"},
		'{CMD_HEX_UP, 64'h1234_5678_89AB_CDEF, "89ABCDEF"},
		'{CMD_HEX_UP, 64'h0000_0000_0000_00F0, PREDICT},
		'{CMD_PTR,    64'd0,                   "0x0"},
		'{CMD_PTR,    64'hFFFF_FFFF_FFFF_FFFF, "0xffffffffffffffff"},
		'{CMD_PTR,    64'h8000_0000_0000_0000, "0x8000000000000000"},
		'{CMD_PTR,    64'd1,                   "0x1"},
		'{CMD_PTR,    64'h0123_4567_89AB_CDEF, PREDICT},
		'{CMD_DEC,    64'hAAAA_AAAA_5555_5555, PREDICT},
		'{CMD_HEX_LO, 64'h5555_5555_5555_5555, PREDICT}
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	cmd_t        cmd;
	logic [63:0] value;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  char_out;
	logic        last;

	phase_t      phase;
	char_exp_t   pending_chars [$];
	int          error_count;
	int          requests_taken;
	int          quiet_cycles;
	int          hold_left;
	bit          hold_done;

	integer_to_ascii_formatter_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.char_out  (char_out),
		.last      (last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("%0t ns: mismatch: %s", $realtime, msg);
	endtask

	function automatic bit draw_pct(input int pct);
		draw_pct = ($urandom_range(0, 99) < pct);
	endfunction

	// Builds the text of one request, least significant character first.
	function automatic logic [143:0] format_number(input cmd_t op, input logic [63:0] val);
		logic [143:0] text;
		logic [31:0]  dec;
		logic [31:0]  rem;
		logic [63:0]  rest;
		logic [3:0]   nib;
		int           n;
		text = '0;
		n = 0;
		if (op == CMD_DEC) begin
			dec = val[31:0];
			do begin
				rem = dec % 32'd10;
				text[8*n +: 8] = 8'h30 + rem[7:0];
				n++;
				dec = dec / 32'd10;
			end while (dec != 32'd0);
		end else begin
			rest = (op == CMD_PTR) ? val : {32'd0, val[31:0]};
			do begin
				nib = rest[3:0];
				if (nib < 4'd10) begin
					text[8*n +: 8] = 8'h30 + {4'd0, nib};
				end else if (op == CMD_HEX_UP) begin
					text[8*n +: 8] = 8'h41 + {4'd0, nib} - 8'd10;
				end else begin
					text[8*n +: 8] = 8'h61 + {4'd0, nib} - 8'd10;
				end
				n++;
				rest = rest >> 4;
			end while (rest != 64'd0);
			if (op == CMD_PTR) begin
				text[8*n +: 8] = "x";
				text[8*(n+1) +: 8] = "0";
			end
		end
		format_number = text;
	endfunction

	function automatic void expect_text(input logic [143:0] text);
		logic [7:0] ch;
		for (int i = 17; i >= 0; i--) begin
			ch = text[8*i +: 8];
			if (ch != 8'd0) begin
				pending_chars.push_back('{ch: ch, fin: (i == 0)});
			end
		end
	endfunction

	function automatic logic [63:0] draw_value();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: begin
				draw_value = raw;
			end
			1: begin
				draw_value = raw >> $urandom_range(0, 63);
			end
			2: begin
				// Junk above bit 31 with a short low word.
				draw_value = {raw[63:32], raw[31:0] >> $urandom_range(0, 31)};
			end
			default: begin
				draw_value = 64'($urandom_range(0, 20));
			end
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic offer_request(input cmd_t op, input logic [63:0] val,
		input logic [143:0] text);
		int gap_pct;
		gap_pct = (phase == PH_SLOW_SRC) ? 72 : (phase == PH_LIGHT_BOTH) ? 7 : 0;
		while (draw_pct(gap_pct)) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= op;
		value    <= val;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expect_text((text != PREDICT) ? text : format_number(op, val));
		@(negedge clk);
	endtask

	// Receiver: random stalls by phase, plus one long hold-off that backs up the block.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (!hold_done && requests_taken >= PRESSURE_AT) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			case (phase)
				PH_SLOW_SINK:  out_stall <= draw_pct(72);
				PH_LIGHT_BOTH: out_stall <= draw_pct(7);
				default:       out_stall <= 1'b0;
			endcase
		end
	end

	always @(posedge clk) begin : char_check
		char_exp_t want;
		if (arst_n && in_valid && !in_stall) begin
			requests_taken++;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (pending_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected char 0x%02h last %0b", char_out, last));
			end else begin
				want = pending_chars.pop_front();
				if (char_out !== want.ch) begin
					report_mismatch($sformatf("char_out 0x%02h, expected 0x%02h",
						char_out, want.ch));
				end
				if (last !== want.fin) begin
					report_mismatch($sformatf("last %0b, expected %0b on char 0x%02h",
						last, want.fin, want.ch));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("integer_to_ascii_formatter_core regression: fail");
				$finish;
			end
		end
	end

	initial begin : stimulus
		cmd_t op;
		in_valid       = 1'b0;
		cmd            = CMD_DEC;
		value          = '0;
		out_stall      = 1'b0;
		arst_n         = 1'b0;
		phase          = PH_STEADY;
		error_count    = 0;
		requests_taken = 0;
		quiet_cycles   = 0;
		hold_left      = 0;
		hold_done      = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < NUM_DIRECTED; i++) begin
			offer_request(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].val, DIRECTED_ROWS[i].text);
		end

		for (int c = 0; c < RANDOM_CHUNKS; c++) begin
			phase = phase_t'(c % 4);
			for (int i = 0; i < CHUNK_ITEMS; i++) begin
				op = cmd_t'($urandom_range(0, 3));
				offer_request(op, draw_value(), PREDICT);
			end
		end
		in_valid <= 1'b0;

		while (pending_chars.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("integer_to_ascii_formatter_core regression: pass");
		end else begin
			$display("integer_to_ascii_formatter_core regression: fail");
		end
		$finish;
	end

endmodule
